// ----- hdl/ocbc_pkg.sv -----
// ----------------------------------------------------------------------------
// ocbc_pkg
// Types and constants shared by the one's complement block checksum modules.
// ----------------------------------------------------------------------------
package ocbc_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int BS_W           = 7;
  localparam int CHK_W          = 64;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;
  localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 7'd16;

  // register index, taken from the word address
  localparam logic REG_BLOCK_SIZE = 1'b0;

  typedef struct packed {
    logic data_bit;
    logic last;
  } ocbc_in_t;

  typedef struct packed {
    logic [CHK_W-1:0] checksum;
    logic             is_zero;
  } ocbc_out_t;

endpackage

// ----- hdl/ones_complement_block_checksum.sv -----
// ----------------------------------------------------------------------------
// ones_complement_block_checksum
// Serial one's complement checksum over words of a programmable width.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one stream bit per request, first bit of each word is its MSB;
//           last marks the final bit and asks for the checksum.
//   out_* : one request per stream: inverted sum in the low block_size bits,
//           upper bits zero, plus is_zero (frame good on receive).
//   APB   : block_size at address 0 (0 acts as 1, above MAX_WIDTH clamps).
// Throughput is one bit per cycle while in_stall is low; the single word
// adder in the back part takes one queued word per cycle, and a final word
// waits while a held result is stalled. The last bit's final word is
// queued, then popped into the result register, which sets out_valid.
// Reset clears the word assembly, running sum, queue and result valid, and
// sets block_size to 16.
// When out_stall holds a result, further words still sum; a second final
// word waits in the queue, and in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module ones_complement_block_checksum import ocbc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ocbc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ocbc_out_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int QW  = 1 + WW + MAX_WIDTH;

  logic [BS_W-1:0]      block_size_r, block_size_nxt;
  logic [WW-1:0]        width;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  logic                 push;
  logic [MAX_WIDTH-1:0] push_word;
  logic [WW-1:0]        push_width;
  logic                 push_last;
  logic [QW-1:0]        q_rdata;

  assign pready = 1'b1;

  always_comb begin
    block_size_nxt = block_size_r;
    if (psel && penable && pwrite && paddr[2] == REG_BLOCK_SIZE) begin
      block_size_nxt = pwdata[BS_W-1:0];
    end
    prdata = '0;
    if (paddr[2] == REG_BLOCK_SIZE) begin
      prdata = APB_DATA_W'(block_size_r);
    end
    if (block_size_r == '0) begin
      width = WW'(1);
    end else if (int'(block_size_r) > MAX_WIDTH) begin
      width = WW'(MAX_WIDTH);
    end else begin
      width = WW'(block_size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLOCK_SIZE_RST;
    end else begin
      block_size_r <= block_size_nxt;
    end
  end

  ocbc_front #(.MAX_WIDTH(MAX_WIDTH), .WW(WW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .width      (width),
    .q_full     (q_full),
    .push       (push),
    .push_word  (push_word),
    .push_width (push_width),
    .push_last  (push_last)
  );

  ocbc_queue #(.DATA_W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({push_last, push_width, push_word}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ocbc_back #(.MAX_WIDTH(MAX_WIDTH), .WW(WW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_word    (q_rdata[MAX_WIDTH-1:0]),
    .q_width   (q_rdata[MAX_WIDTH+WW-1:MAX_WIDTH]),
    .q_last    (q_rdata[QW-1]),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/ocbc_front.sv -----
// ----------------------------------------------------------------------------
// ocbc_front
// Accepts stream bits, assembles words and queues one add request for each
// completed word or final padded partial word.
// ----------------------------------------------------------------------------
module ocbc_front import ocbc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ocbc_in_t             in_data,
  input  logic [WW-1:0]        width,
  input  logic                 q_full,
  output logic                 push,
  output logic [MAX_WIDTH-1:0] push_word,
  output logic [WW-1:0]        push_width,
  output logic                 push_last
);

  logic [MAX_WIDTH-1:0] word_r, word_nxt;
  logic [WW-1:0]        cnt_r, cnt_nxt;
  logic                 accept;
  logic [MAX_WIDTH-1:0] word_sh;
  logic [MAX_WIDTH-1:0] mask;
  logic [WW-1:0]        cnt_inc;
  logic [WW-1:0]        pad;
  logic                 done;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    word_sh    = {word_r[MAX_WIDTH-2:0], in_data.data_bit};
    cnt_inc    = cnt_r + WW'(1);
    done       = (cnt_inc >= width);
    pad        = width - cnt_inc;
    mask       = ~({MAX_WIDTH{1'b1}} << width);
    push       = 1'b0;
    push_word  = word_sh & mask;
    push_width = width;
    push_last  = in_data.last;
    word_nxt   = word_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      if (done) begin
        push     = 1'b1;
        word_nxt = '0;
        cnt_nxt  = '0;
      end else if (in_data.last) begin
        push      = 1'b1;
        push_word = (word_sh << pad) & mask;
        word_nxt  = '0;
        cnt_nxt   = '0;
      end else begin
        word_nxt = word_sh;
        cnt_nxt  = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      cnt_r  <= '0;
    end else begin
      word_r <= word_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/ocbc_queue.sv -----
// ----------------------------------------------------------------------------
// ocbc_queue
// Two-entry queue of add requests between the front and back parts.
// ----------------------------------------------------------------------------
module ocbc_queue import ocbc_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              full,
  output logic              empty
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  assign rdata = mem_r[rd_ptr_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/ocbc_back.sv -----
// ----------------------------------------------------------------------------
// ocbc_back
// Adds queued words into the running sum with end-around carry and
// registers the inverted sum as the result on the final word.
// ----------------------------------------------------------------------------
module ocbc_back import ocbc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  logic [MAX_WIDTH-1:0] q_word,
  input  logic [WW-1:0]        q_width,
  input  logic                 q_last,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ocbc_out_t            out_data
);

  logic [MAX_WIDTH-1:0] sum_r, sum_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ocbc_out_t            out_data_r, out_data_nxt;
  logic [MAX_WIDTH-1:0] mask;
  logic [MAX_WIDTH:0]   raw;
  logic [MAX_WIDTH-1:0] total;
  logic [MAX_WIDTH-1:0] chk;
  logic                 out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    pop           = !q_empty && (!q_last || out_free);
    mask          = ~({MAX_WIDTH{1'b1}} << q_width);
    raw           = {1'b0, sum_r & mask} + {1'b0, q_word & mask};
    total         = (raw[MAX_WIDTH-1:0] + MAX_WIDTH'(raw[q_width])) & mask;
    chk           = ~total & mask;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (pop) begin
      if (q_last) begin
        sum_nxt               = '0;
        out_valid_nxt         = 1'b1;
        out_data_nxt.checksum = CHK_W'(chk);
        out_data_nxt.is_zero  = (chk == '0);
      end else begin
        sum_nxt = total;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/ocbc_checker.sv -----
// ----------------------------------------------------------------------------
// ocbc_checker
// Port-level checks for the one's complement block checksum, bound to the
// top level.
// ----------------------------------------------------------------------------
module ocbc_checker import ocbc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input ocbc_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input ocbc_out_t out_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // zero flag agrees with the checksum
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_zero == (out_data.checksum == '0)))
    else $error("is_zero does not match checksum");

  // reset drops any pending result
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // queue is empty after reset, so input is open
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind ones_complement_block_checksum ocbc_checker u_ocbc_checker (.*);
